// ===== hdl/dotq_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dotq_pkg
// Shared types and codes for the deadline-ordered timer queue.
// ---------------------------------------------------------------------------
package dotq_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned ID_W   = 5;
	localparam int unsigned REM_W  = 31;

	typedef enum logic [1:0] {
		OP_ARM     = 2'd0,
		OP_CANCEL  = 2'd1,
		OP_FIRE    = 2'd2,
		OP_ADVANCE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_EXPIRED = 2'd1,
		KIND_REMAIN  = 2'd2,
		KIND_EMPTY   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_SHL,
		ST_INS,
		ST_SHR,
		ST_ADV,
		ST_EMIT
	} state_t;

	// result waiting for the output register
	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   id;
		logic [REM_W-1:0]  rem;
		logic              status;
		logic              last;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/dotq_ifs.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dotq_cmd_if / dotq_res_if
// Valid/ready channels for commands into and results out of the timer queue.
// ---------------------------------------------------------------------------
interface dotq_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [4:0]         timer_id;
	logic signed [31:0] delay_ms;
	logic [31:0]        now_ms;

	modport source (output valid, output opcode, output timer_id, output delay_ms,
		output now_ms, input ready);
	modport sink (input valid, input opcode, input timer_id, input delay_ms,
		input now_ms, output ready);
endinterface

interface dotq_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [4:0]  expired_id;
	logic [30:0] remaining_ms;
	logic        status;
	logic        last;

	modport source (output valid, output kind, output expired_id, output remaining_ms,
		output status, output last, input ready);
	modport sink (input valid, input kind, input expired_id, input remaining_ms,
		input status, input last, output ready);
endinterface
`default_nettype wire

// ===== hdl/deadline_ordered_timer_queue_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// deadline_ordered_timer_queue_unit
// Timer queue kept as a deadline-ordered list in a small RAM, walked by a
// sequencer around one shared subtractor.
// ---------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  cmd     | in  | valid/ready | opcode, timer_id, delay_ms, now_ms
//  res     | out | valid/ready | kind, expired_id, remaining_ms, status, last
//
//  One list entry per cycle: cancel/unlink walks to the entry and closes the
//  gap; arm scans for its slot and shifts the tail; advance unlinks each expired timer.
//  cmd.ready is high only between commands; the list RAM's single write port
//  and registered read port set the pace. Results leave through an output
//  register, a stalled res channel holds the sequencer in its emit step.
//  Reset clears the armed flags and the count; no clearing pass.
// ---------------------------------------------------------------------------
module deadline_ordered_timer_queue_unit #(
	parameter int unsigned TIMERS = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dotq_cmd_if.sink   cmd,
	dotq_res_if.source res
);
	import dotq_pkg::*;

	localparam int unsigned IW = $clog2(TIMERS);
	localparam int unsigned PW = $clog2(TIMERS + 1);
	localparam int unsigned EW = IW + TIME_W;

	state_t            st_q, st_d;
	op_t               op_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] when_q, now_q;
	logic [PW-1:0]     ptr_q, ptr_d, pos_q, cnt_q;
	logic [TIMERS-1:0] armed_q;
	logic [EW-1:0]     list_mem [TIMERS];
	logic [EW-1:0]     rd_q;
	result_t           pend_q, pend_d;
	logic              pend_ld;
	result_t           out_q;
	logic              out_v_q;

	logic [PW-1:0]     raddr, waddr;
	logic              we;
	logic [EW-1:0]     wdata;
	logic              arm_set, arm_clr, cnt_inc, cnt_dec, pos_ld, cmd_fire, emit_fire;
	logic [IW-1:0]     arm_idx;
	logic [ID_W-1:0]   id_ld;
	logic              id_ld_en;

	logic [IW-1:0]     rd_id;
	logic [TIME_W-1:0] rd_dl;
	logic [TIME_W-1:0] alu_a, alu_b, alu_diff;
	logic              alu_ab, alu_ba;
	logic [TIME_W-1:0] delay_clamped;
	logic              id_bad;
	logic              out_free;

	assign rd_id = rd_q[EW-1:TIME_W];
	assign rd_dl = rd_q[TIME_W-1:0];

	assign cmd.ready = (st_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign out_free  = !out_v_q || res.ready;
	assign id_bad    = ({2'b00, cmd.timer_id} >= 7'(TIMERS));
	assign delay_clamped = cmd.delay_ms[31] ? '0 : cmd.delay_ms;

	// insertion compares when - dl; advance works on dl - now
	assign alu_a = (st_q == ST_INS) ? when_q : rd_dl;
	assign alu_b = (st_q == ST_INS) ? rd_dl  : now_q;

	dotq_alu u_alu (
		.a          (alu_a),
		.b          (alu_b),
		.diff       (alu_diff),
		.a_before_b (alu_ab),
		.b_before_a (alu_ba)
	);

	always_comb begin
		st_d     = st_q;
		ptr_d    = ptr_q;
		raddr    = '0;
		we       = 1'b0;
		waddr    = '0;
		wdata    = rd_q;
		arm_set  = 1'b0;
		arm_clr  = 1'b0;
		arm_idx  = IW'(id_q);
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		pos_ld   = 1'b0;
		pend_ld  = 1'b0;
		pend_d   = '{kind: KIND_ACK, id: id_q, rem: '0, status: 1'b0, last: 1'b1};
		emit_fire = 1'b0;
		id_ld    = ID_W'(rd_id);
		id_ld_en = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				arm_idx = IW'(cmd.timer_id);
				pend_d.id = cmd.timer_id;
				if (cmd_fire) begin
					ptr_d = '0;
					if (op_t'(cmd.opcode) != OP_ADVANCE && id_bad) begin
						pend_d.status = 1'b1;
						pend_ld = 1'b1;
						st_d = ST_EMIT;
					end else if (op_t'(cmd.opcode) == OP_ADVANCE) begin
						st_d = ST_ADV;
					end else if (armed_q[IW'(cmd.timer_id)]) begin
						arm_clr = 1'b1;
						st_d = ST_FIND;
					end else if (op_t'(cmd.opcode) == OP_ARM) begin
						st_d = ST_INS;
					end else begin
						pend_d.status = 1'b1;
						pend_ld = 1'b1;
						st_d = ST_EMIT;
					end
				end
			end
			ST_FIND: begin
				ptr_d = ptr_q + PW'(1);
				raddr = ptr_d;
				if (rd_id == IW'(id_q))
					st_d = ST_SHL;
			end
			ST_SHL: begin
				if (ptr_q < cnt_q) begin
					we    = 1'b1;
					waddr = ptr_q - PW'(1);
					ptr_d = ptr_q + PW'(1);
					raddr = ptr_d;
				end else begin
					cnt_dec = 1'b1;
					ptr_d   = '0;
					unique case (op_q)
						OP_ARM:     st_d = ST_INS;
						OP_CANCEL: begin
							pend_ld = 1'b1;
							st_d = ST_EMIT;
						end
						OP_FIRE: begin
							pend_d.kind = KIND_EXPIRED;
							pend_ld = 1'b1;
							st_d = ST_EMIT;
						end
						OP_ADVANCE: begin
							pend_d.kind = KIND_EXPIRED;
							pend_d.last = 1'b0;
							pend_ld = 1'b1;
							st_d = ST_EMIT;
						end
						default: st_d = ST_IDLE;
					endcase
				end
			end
			ST_INS: begin
				if (ptr_q < cnt_q && !alu_ab) begin
					ptr_d = ptr_q + PW'(1);
					raddr = ptr_d;
				end else begin
					pos_ld = 1'b1;
					ptr_d  = cnt_q;
					raddr  = cnt_q - PW'(1);
					st_d   = ST_SHR;
				end
			end
			ST_SHR: begin
				we = 1'b1;
				if (ptr_q > pos_q) begin
					waddr = ptr_q;
					ptr_d = ptr_q - PW'(1);
					raddr = ptr_q - PW'(2);
				end else begin
					waddr   = pos_q;
					wdata   = {IW'(id_q), when_q};
					arm_set = 1'b1;
					cnt_inc = 1'b1;
					pend_ld = 1'b1;
					st_d    = ST_EMIT;
				end
			end
			ST_ADV: begin
				pend_d.id = '0;
				if (cnt_q == '0) begin
					pend_d.kind = KIND_EMPTY;
					pend_ld = 1'b1;
					st_d = ST_EMIT;
				end else if (alu_ba) begin
					pend_d.kind = KIND_REMAIN;
					pend_d.rem  = alu_diff[REM_W-1:0];
					pend_ld = 1'b1;
					st_d = ST_EMIT;
				end else begin
					// head is due: unlink entry 0
					arm_idx  = rd_id;
					arm_clr  = 1'b1;
					id_ld_en = 1'b1;
					ptr_d    = PW'(1);
					raddr    = PW'(1);
					st_d     = ST_SHL;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit_fire = 1'b1;
					st_d = pend_q.last ? ST_IDLE : ST_ADV;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			cnt_q   <= '0;
			armed_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cnt_inc)
				cnt_q <= cnt_q + PW'(1);
			else if (cnt_dec)
				cnt_q <= cnt_q - PW'(1);
			if (arm_set)
				armed_q[arm_idx] <= 1'b1;
			else if (arm_clr)
				armed_q[arm_idx] <= 1'b0;
			if (emit_fire)
				out_v_q <= 1'b1;
			else if (res.ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		if (cmd_fire) begin
			op_q   <= op_t'(cmd.opcode);
			id_q   <= cmd.timer_id;
			now_q  <= cmd.now_ms;
			when_q <= cmd.now_ms + delay_clamped;
		end else if (id_ld_en) begin
			id_q <= id_ld;
		end
		if (pos_ld)
			pos_q <= ptr_q;
		if (pend_ld)
			pend_q <= pend_d;
		if (emit_fire)
			out_q <= pend_q;
	end

	// list RAM: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (we)
			list_mem[waddr[IW-1:0]] <= wdata;
		rd_q <= list_mem[raddr[IW-1:0]];
	end

	assign res.valid        = out_v_q;
	assign res.kind         = out_q.kind;
	assign res.expired_id   = out_q.id;
	assign res.remaining_ms = out_q.rem;
	assign res.status       = out_q.status;
	assign res.last         = out_q.last;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= PW'(TIMERS))
		else $error("queued count above capacity");

	a_cnt_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> ($countones(armed_q) == int'(cnt_q)))
		else $error("armed flags disagree with queued count");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> !cmd.ready)
		else $error("command taken while sequencer idle next cycle");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |-> (!out_v_q || res.ready))
		else $error("result overwrote a pending transaction");

endmodule
`default_nettype wire

// ===== hdl/dotq_alu.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dotq_alu
// Shared time subtractor: difference a - b and the wrap-safe ordering flags.
// ---------------------------------------------------------------------------
module dotq_alu (
	input  wire logic [dotq_pkg::TIME_W-1:0] a,
	input  wire logic [dotq_pkg::TIME_W-1:0] b,
	output logic      [dotq_pkg::TIME_W-1:0] diff,
	output logic                             a_before_b,
	output logic                             b_before_a
);
	import dotq_pkg::*;

	assign diff       = a - b;
	assign a_before_b = diff[TIME_W-1];
	// b - a = -diff lands in the upper half when diff is in (0, 2^31]
	assign b_before_a = (diff != '0) && (!diff[TIME_W-1] || (diff[TIME_W-2:0] == '0));

endmodule
`default_nettype wire
